/* sv/md5_pkg.sv */
package md5_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RND_RD,
		ST_RND,
		ST_ADD,
		ST_EMIT
	} md5_state_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] r;
		case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;   4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
			4'd4: r = 5'd5;   4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
			4'd8: r = 5'd4;   4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	// message word index per round
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage

/* sv/md5_if.sv */
interface md5_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       last;
	modport source (output valid, data_byte, has_data, last, input ready);
	modport sink (input valid, data_byte, has_data, last, output ready);
endinterface

interface md5_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/md5_hash_engine_unit.sv */
// Byte items are accepted back to back while the block is filling.
// A byte completing a block stalls input for 64 rounds, each a word read from
// the 16x32 buffer RAM, then one shared round adder, plus the final add.
// A last item adds up to 64 pad bytes per block and two compressions at most,
// then 4 digest words are emitted one per output request.
// Reset (arst_n low) loads the MD5 initial chaining words and zeroes the bit count.
module md5_hash_engine_unit
	import md5_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	md5_in_if.sink   in_ch,
	md5_out_if.source out_ch
);
	md5_state_t  state_q, state_d;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] bit_count_q;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic        fin_q;     // pad byte written
	logic        len_blk_q; // current padding block carries length
	logic        pend_q;    // last byte filled the block, padding follows compress
	logic [1:0]  widx_q;
	logic [23:0] wacc_q;

	// buffer RAM: 16 words, written a word at a time on every 4th byte
	logic        we;
	logic [3:0]  waddr, raddr;
	logic [31:0] wdata, rdata;
	logic [7:0]  wbyte;

	md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic        acc_in;
	logic        wr_byte;
	logic [31:0] f, sum, rot;
	logic [4:0]  sh;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc_in = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.digest_word = h_q[widx_q];
	assign out_ch.word_index = widx_q;
	assign out_ch.last_word = (widx_q == 2'd3);

	// write byte selection: input data, length, pad or zero byte
	always_comb begin
		if (state_q == ST_IDLE)
			wbyte = in_ch.data_byte;
		else if (len_blk_q && pos_q >= LEN_POS)
			wbyte = len_q[{pos_q[2:0], 3'b000} +: 8];
		else if (!fin_q)
			wbyte = PAD_BYTE;
		else
			wbyte = 8'h00;
	end

	assign wr_byte = (acc_in && in_ch.has_data) || (state_q == ST_PAD);
	assign we = wr_byte && (pos_q[1:0] == 2'd3);
	assign waddr = pos_q[5:2];
	assign wdata = {wbyte, wacc_q};
	assign raddr = md5_g(rnd_q);

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sh = md5_rot(rnd_q);
		sum = a_q + f + md5_k(rnd_q) + rdata;
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					if (in_ch.has_data && pos_q == 6'd63)
						state_d = ST_RND_RD;
					else if (in_ch.last)
						state_d = ST_PAD;
				end
			end
			ST_PAD: if (pos_q == 6'd63) state_d = ST_RND_RD;
			ST_RND_RD: state_d = ST_RND;
			ST_RND: state_d = (rnd_q == 6'd63) ? ST_ADD : ST_RND_RD;
			ST_ADD: begin
				if (fin_q || pend_q)
					state_d = len_blk_q ? ST_EMIT : ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT: if (out_ch.ready && widx_q == 2'd3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			bit_count_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			len_blk_q <= 1'b0;
			widx_q <= '0;
			wacc_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_byte) begin
				pos_q <= pos_q + 6'd1;
				wacc_q <= {wbyte, wacc_q[23:8]};
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (in_ch.has_data)
							bit_count_q <= bit_count_q + 64'd8;
						if (in_ch.last) begin
							fin_q <= 1'b0;
							len_q <= in_ch.has_data ? bit_count_q + 64'd8 : bit_count_q;
							// pad byte lands at the next position
							len_blk_q <= (in_ch.has_data ? pos_q + 6'd1 : pos_q) < LEN_POS
								&& !(in_ch.has_data && pos_q == 6'd63);
						end
					end
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					rnd_q <= '0;
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					if (!fin_q && pos_q >= LEN_POS)
						len_blk_q <= 1'b0;
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					rnd_q <= '0;
				end
				ST_RND_RD: ;
				ST_RND: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= b_q + rot;
					rnd_q <= rnd_q + 6'd1;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					if (!len_blk_q) len_blk_q <= 1'b1;
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						widx_q <= widx_q + 2'd1;
						if (widx_q == 2'd3) begin
							h_q[0] <= IV_A; h_q[1] <= IV_B;
							h_q[2] <= IV_C; h_q[3] <= IV_D;
							bit_count_q <= '0;
							fin_q <= 1'b0;
							pos_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// last item whose byte fills the block: compress, then pad from ST_ADD
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else if (acc_in && in_ch.has_data && pos_q == 6'd63 && in_ch.last)
			pend_q <= 1'b1;
		else if (state_q == ST_ADD)
			pend_q <= 1'b0;
	end
endmodule

/* sv/md5_ram.sv */
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
